>>> hdl/cief_pkg.sv
// ----------------------------------------------------------------------------
// Coalescing input event FIFO package
// Shared widths, codes, entry layout and ring index helpers.
// ----------------------------------------------------------------------------
package cief_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int KIND_W     = 8;
    localparam int TYPE_W     = 4;
    localparam int DEV_W      = 8;
    localparam int CONTACT_W  = 4;
    localparam int BTN_W      = 8;
    localparam int SERIAL_W   = 32;
    localparam int PAYLOAD_W  = 64;
    localparam int OUTCOME_W  = 2;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int RESERVE_W  = 4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Opcodes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Sink outcomes; any other code counts as an error
    localparam logic [OUTCOME_W-1:0] OUTCOME_ACCEPT = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_BUSY   = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TYPE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOVER_TYPE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE      = 2'd3;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_SKIPPED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_SENT     = 3'd4,
        ST_BUSY     = 3'd5,
        ST_ERROR    = 3'd6,
        ST_EMPTY    = 3'd7
    } status_t;

    // Fields that must match for a motion event to merge
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [TYPE_W-1:0]    ptype;
        logic [DEV_W-1:0]     device;
        logic [CONTACT_W-1:0] contact;
        logic [BTN_W-1:0]     buttons;
        logic [SERIAL_W-1:0]  serial;
    } key_t;

    // One queued event
    typedef struct packed {
        key_t                 key;
        logic [PAYLOAD_W-1:0] payload;
    } event_t;

    // Write request into the event store
    typedef struct packed {
        logic   en;
        idx_t   idx;
        event_t data;
    } store_wr_t;

    // Ring index advance with wrap
    function automatic idx_t idx_next(input idx_t idx);
        idx_t res;
        if (idx == idx_t'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end
        else begin
            res = idx + idx_t'(1);
        end
        return res;
    endfunction

    // Ring index step back with wrap
    function automatic idx_t idx_prev(input idx_t idx);
        idx_t res;
        if (idx == '0) begin
            res = idx_t'(QUEUE_DEPTH - 1);
        end
        else begin
            res = idx - idx_t'(1);
        end
        return res;
    endfunction

endpackage

>>> hdl/cief_if.sv
// ----------------------------------------------------------------------------
// Coalescing input event FIFO channels
// Valid/ready channels for event transactions and result transactions.
// ----------------------------------------------------------------------------
interface cief_in_if import cief_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [KIND_W-1:0]    event_kind;
    logic [TYPE_W-1:0]    pointer_type;
    logic [DEV_W-1:0]     device_number;
    logic [CONTACT_W-1:0] contact_number;
    logic [BTN_W-1:0]     button_mask;
    logic [SERIAL_W-1:0]  serial_number;
    logic [PAYLOAD_W-1:0] payload;
    logic [OUTCOME_W-1:0] sink_outcome;

    modport source (
        output valid, opcode, event_kind, pointer_type, device_number,
               contact_number, button_mask, serial_number, payload, sink_outcome,
        input  ready
    );

    modport sink (
        input  valid, opcode, event_kind, pointer_type, device_number,
               contact_number, button_mask, serial_number, payload, sink_outcome,
        output ready
    );
endinterface

interface cief_out_if import cief_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [KIND_W-1:0]    out_kind;
    logic [TYPE_W-1:0]    out_type;
    logic [DEV_W-1:0]     out_device;
    logic [CONTACT_W-1:0] out_contact;
    logic [BTN_W-1:0]     out_buttons;
    logic [SERIAL_W-1:0]  out_serial;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [FILL_W-1:0]    fill_level;

    modport source (
        output valid, status, out_kind, out_type, out_device, out_contact,
               out_buttons, out_serial, out_payload, fill_level,
        input  ready
    );

    modport sink (
        input  valid, status, out_kind, out_type, out_device, out_contact,
               out_buttons, out_serial, out_payload, fill_level,
        output ready
    );
endinterface

>>> hdl/coalescing_input_event_fifo_core.sv
// ----------------------------------------------------------------------------
// Coalescing input event FIFO core
// Queues input events, merges repeated pointer motion, drains the head entry.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake     Contents
//  in_ch    sink       valid/ready   push event or drain attempt with outcome
//  out_ch   source     valid/ready   status, sent entry, fill level
//  cfg      write      cfg_wr_en     pointer kind, move/hover type, reserve
//
//  One transaction per cycle sustained while results are taken: an input
//  register feeds one pass of compare/select logic into a result register.
//  The head entry is prefetched from the store every cycle, so a drain
//  needs no separate read step. Reset empties the queue at once (no sweep).
//  A stalled result holds the processing stage; input stays open while
//  the input register is free or draining into the result register.
//
module coalescing_input_event_fifo_core import cief_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cief_in_if.sink               in_ch,
    cief_out_if.source            out_ch
);

    localparam int SUM_W = ((CNT_W > RESERVE_W) ? CNT_W : RESERVE_W) + 1;

    // Configuration registers
    logic [KIND_W-1:0]    pointer_kind_reg;
    logic [TYPE_W-1:0]    move_type_reg;
    logic [TYPE_W-1:0]    hover_type_reg;
    logic [RESERVE_W-1:0] reserve_reg;

    // Queue state
    idx_t   head_reg;
    idx_t   tail_reg;
    cnt_t   count_reg;
    key_t   tail_key_reg;
    idx_t   head_next;
    idx_t   tail_next;
    cnt_t   count_next;

    // Input register
    logic                 in_valid_reg;
    logic                 in_op_reg;
    event_t               in_event_reg;
    logic [OUTCOME_W-1:0] in_outcome_reg;

    // Result register
    logic                 res_valid_reg;
    status_t              res_status_reg;
    event_t               res_event_reg;
    logic [FILL_W-1:0]    res_fill_reg;

    // Processing signals
    logic      fire;
    logic      in_accept;
    status_t   status_next;
    event_t    res_event_next;
    logic      pop;
    logic      append;
    logic      is_motion;
    logic      key_match;
    logic      reserve_hit;
    store_wr_t store_wr;
    event_t    head_data;

    assign fire      = in_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || fire;
    assign in_accept = in_ch.valid && in_ch.ready;

    // Hold configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_kind_reg <= KIND_W'(1);
            move_type_reg    <= TYPE_W'(1);
            hover_type_reg   <= TYPE_W'(2);
            reserve_reg      <= RESERVE_W'(4);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_POINTER_KIND: pointer_kind_reg <= cfg_data[KIND_W-1:0];
                CFG_MOVE_TYPE:    move_type_reg    <= cfg_data[TYPE_W-1:0];
                CFG_HOVER_TYPE:   hover_type_reg   <= cfg_data[TYPE_W-1:0];
                CFG_RESERVE:      reserve_reg      <= cfg_data[RESERVE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Classify the pending transaction against the queue state
    assign is_motion = (in_event_reg.key.kind == pointer_kind_reg) &&
                       ((in_event_reg.key.ptype == move_type_reg) ||
                        (in_event_reg.key.ptype == hover_type_reg));
    assign key_match = (count_reg != '0) && (tail_key_reg == in_event_reg.key);
    assign reserve_hit = (SUM_W'(count_reg) + SUM_W'(reserve_reg)) >=
                         SUM_W'(QUEUE_DEPTH);

    // Decide the status, the store write and the pointer moves
    always_comb
    begin
        status_next    = ST_EMPTY;
        res_event_next = '0;
        pop            = 1'b0;
        append         = 1'b0;
        store_wr.en    = 1'b0;
        store_wr.idx   = tail_reg;
        store_wr.data  = in_event_reg;

        if (in_op_reg == OP_DRAIN)
        begin
            if (count_reg == '0)
            begin
                status_next = ST_EMPTY;
            end
            else if (in_outcome_reg == OUTCOME_BUSY)
            begin
                status_next = ST_BUSY;
            end
            else if (in_outcome_reg != OUTCOME_ACCEPT)
            begin
                status_next = ST_ERROR;
            end
            else
            begin
                status_next    = ST_SENT;
                res_event_next = head_data;
                pop            = fire;
            end
        end
        else
        begin
            if (is_motion && key_match)
            begin
                status_next  = ST_MERGED;
                store_wr.en  = fire;
                store_wr.idx = idx_prev(tail_reg);
            end
            else if (is_motion && reserve_hit)
            begin
                status_next = ST_SKIPPED;
            end
            else if (count_reg == cnt_t'(QUEUE_DEPTH))
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_APPENDED;
                append      = fire;
                store_wr.en = fire;
            end
        end

        head_next  = pop ? idx_next(head_reg) : head_reg;
        tail_next  = append ? idx_next(tail_reg) : tail_reg;
        count_next = count_reg;
        if (append)
        begin
            count_next = count_reg + cnt_t'(1);
        end
        else if (pop)
        begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    // Entry store, head prefetched at the post-update head index
    cief_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_idx  (head_next),
        .rd_data (head_data)
    );

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Capture input transaction, newest key and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg                  <= in_ch.opcode;
            in_event_reg.key.kind      <= in_ch.event_kind;
            in_event_reg.key.ptype     <= in_ch.pointer_type;
            in_event_reg.key.device    <= in_ch.device_number;
            in_event_reg.key.contact   <= in_ch.contact_number;
            in_event_reg.key.buttons   <= in_ch.button_mask;
            in_event_reg.key.serial    <= in_ch.serial_number;
            in_event_reg.payload       <= in_ch.payload;
            in_outcome_reg             <= in_ch.sink_outcome;
        end
        if (append)
        begin
            tail_key_reg <= in_event_reg.key;
        end
        if (fire)
        begin
            res_status_reg <= status_next;
            res_event_reg  <= res_event_next;
            res_fill_reg   <= FILL_W'(count_next);
        end
    end

    // Drive the result channel
    assign out_ch.valid       = res_valid_reg;
    assign out_ch.status      = res_status_reg;
    assign out_ch.out_kind    = res_event_reg.key.kind;
    assign out_ch.out_type    = res_event_reg.key.ptype;
    assign out_ch.out_device  = res_event_reg.key.device;
    assign out_ch.out_contact = res_event_reg.key.contact;
    assign out_ch.out_buttons = res_event_reg.key.buttons;
    assign out_ch.out_serial  = res_event_reg.key.serial;
    assign out_ch.out_payload = res_event_reg.payload;
    assign out_ch.fill_level  = res_fill_reg;

endmodule

>>> hdl/cief_store.sv
// ----------------------------------------------------------------------------
// Coalescing input event FIFO entry store
// Ring storage with one write port and a registered head read with bypass.
// ----------------------------------------------------------------------------
module cief_store import cief_pkg::*;
(
    input  logic      clk,
    input  store_wr_t wr,
    input  idx_t      rd_idx,
    output event_t    rd_data
);

    event_t mem [QUEUE_DEPTH];
    event_t rd_data_reg;

    // Write the tail or newest entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
    end

    // Read the head entry; forward a same-cycle write to the same slot
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == rd_idx))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/tb_coalescing_input_event_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing input event FIFO core testbench
// Drives push and drain transactions with random idling on both channels,
// predicts every result in a scoreboard and checks it field by field.
// ----------------------------------------------------------------------------
import cief_pkg::*;

// One input transaction as seen on the event channel
typedef struct packed {
    logic                 opcode;
    event_t               ev;
    logic [OUTCOME_W-1:0] outcome;
} fifo_cmd_t;

// One result transaction as seen on the result channel
typedef struct packed {
    status_t           status;
    event_t            entry;
    logic [FILL_W-1:0] fill;
} fifo_result_t;

// Queue mirror and result checker
class event_fifo_scoreboard;
    event_t               slots [QUEUE_DEPTH];
    int unsigned          head_pos;
    int unsigned          queued;
    logic [KIND_W-1:0]    kind_code;
    logic [TYPE_W-1:0]    move_code;
    logic [TYPE_W-1:0]    hover_code;
    logic [RESERVE_W-1:0] reserve;
    fifo_result_t         expected_results [$];
    int unsigned          error_count;

    function new();
        head_pos    = 0;
        queued      = 0;
        kind_code   = 8'd1;
        move_code   = 4'd1;
        hover_code  = 4'd2;
        reserve     = 4'd4;
        error_count = 0;
    endfunction

    // Keep only the register's own width, as the block does
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_POINTER_KIND: kind_code  = data[KIND_W-1:0];
            CFG_MOVE_TYPE:    move_code  = data[TYPE_W-1:0];
            CFG_HOVER_TYPE:   hover_code = data[TYPE_W-1:0];
            CFG_RESERVE:      reserve    = data[RESERVE_W-1:0];
            default: ;
        endcase
    endfunction

    // Apply one transaction to the mirror and return the result it causes
    function fifo_result_t apply_transaction(fifo_cmd_t c);
        fifo_result_t r;
        logic         motion;
        int unsigned  last_pos;
        r.status = ST_APPENDED;
        r.entry  = '0;
        if (c.opcode == OP_DRAIN) begin
            if (queued == 0) begin
                r.status = ST_EMPTY;
            end
            else if (c.outcome == OUTCOME_BUSY) begin
                r.status = ST_BUSY;
            end
            else if (c.outcome != OUTCOME_ACCEPT) begin
                r.status = ST_ERROR;
            end
            else begin
                r.status = ST_SENT;
                r.entry  = slots[head_pos];
                head_pos = (head_pos + 1) % QUEUE_DEPTH;
                queued--;
            end
        end
        else begin
            motion = (c.ev.key.kind == kind_code) &&
                     (c.ev.key.ptype == move_code || c.ev.key.ptype == hover_code);
            last_pos = (head_pos + queued + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            if (motion && queued != 0 && slots[last_pos].key == c.ev.key) begin
                // coalesce into the newest entry
                slots[last_pos].payload = c.ev.payload;
                r.status = ST_MERGED;
            end
            else if (motion && queued + reserve >= QUEUE_DEPTH) begin
                r.status = ST_SKIPPED;
            end
            else if (queued >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                slots[(head_pos + queued) % QUEUE_DEPTH] = c.ev;
                queued++;
            end
        end
        r.fill = queued[FILL_W-1:0];
        return r;
    endfunction

    function void note_transaction(fifo_cmd_t c);
        expected_results.push_back(apply_transaction(c));
    endfunction

    function void compare_field(string name, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
            error_count++;
        end
    endfunction

    function void check_result(fifo_result_t got);
        fifo_result_t exp;
        if (expected_results.size() == 0) begin
            $error("result with no transaction outstanding: status %0d", got.status);
            error_count++;
            return;
        end
        exp = expected_results.pop_front();
        compare_field("status", exp.status, got.status);
        compare_field("out_kind", exp.entry.key.kind, got.entry.key.kind);
        compare_field("out_type", exp.entry.key.ptype, got.entry.key.ptype);
        compare_field("out_device", exp.entry.key.device, got.entry.key.device);
        compare_field("out_contact", exp.entry.key.contact, got.entry.key.contact);
        compare_field("out_buttons", exp.entry.key.buttons, got.entry.key.buttons);
        compare_field("out_serial", exp.entry.key.serial, got.entry.key.serial);
        compare_field("out_payload", exp.entry.payload, got.entry.payload);
        compare_field("fill_level", exp.fill, got.fill);
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction
endclass

module tb_coalescing_input_event_fifo_core;

    localparam logic [OUTCOME_W-1:0] OUTCOME_ERROR = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_UNDEF = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 130;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cief_in_if  in_ch ();
    cief_out_if out_ch ();

    event_fifo_scoreboard sb = new();

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold_cycles;
    int unsigned drain_pct;
    key_t        last_motion_key;
    logic        motion_key_valid;

    coalescing_input_event_fifo_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        fifo_result_t got;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.status              = status_t'(out_ch.status);
            got.entry.key.kind      = out_ch.out_kind;
            got.entry.key.ptype     = out_ch.out_type;
            got.entry.key.device    = out_ch.out_device;
            got.entry.key.contact   = out_ch.out_contact;
            got.entry.key.buttons   = out_ch.out_buttons;
            got.entry.key.serial    = out_ch.out_serial;
            got.entry.payload       = out_ch.out_payload;
            got.fill                = out_ch.fill_level;
            sb.check_result(got);
        end
    end

    // Drive result ready: long hold-offs on request, short random stalls otherwise
    initial
    begin : result_receiver
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_cycles != 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
                out_ch.ready <= 1'b1;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Bound the run
    initial
    begin : watchdog
        #(2_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic fifo_cmd_t push_event(
        logic [KIND_W-1:0]    kind,
        logic [TYPE_W-1:0]    ptype,
        logic [DEV_W-1:0]     device,
        logic [CONTACT_W-1:0] contact,
        logic [BTN_W-1:0]     buttons,
        logic [SERIAL_W-1:0]  serial,
        logic [PAYLOAD_W-1:0] payload
    );
        fifo_cmd_t c;
        c.opcode          = OP_PUSH;
        c.ev.key.kind     = kind;
        c.ev.key.ptype    = ptype;
        c.ev.key.device   = device;
        c.ev.key.contact  = contact;
        c.ev.key.buttons  = buttons;
        c.ev.key.serial   = serial;
        c.ev.payload      = payload;
        c.outcome         = OUTCOME_W'($urandom);
        return c;
    endfunction

    // Event fields are random and must be ignored on a drain
    function automatic fifo_cmd_t drain_attempt(logic [OUTCOME_W-1:0] outcome);
        fifo_cmd_t c;
        c.opcode  = OP_DRAIN;
        c.ev      = {$urandom, $urandom, $urandom, $urandom};
        c.outcome = outcome;
        return c;
    endfunction

    function automatic fifo_cmd_t random_command();
        fifo_cmd_t   c;
        int unsigned pick;
        c = drain_attempt(OUTCOME_W'($urandom));
        c.opcode = OP_PUSH;
        pick = $urandom_range(0, 99);
        if (pick < drain_pct) begin
            c.opcode = OP_DRAIN;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                c.outcome = OUTCOME_ACCEPT;
            end
            else if (pick < 82) begin
                c.outcome = OUTCOME_BUSY;
            end
            else if (pick < 94) begin
                c.outcome = OUTCOME_ERROR;
            end
            else begin
                c.outcome = OUTCOME_UNDEF;
            end
        end
        else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // Repeat the previous motion key most of the time so it can coalesce
                if (motion_key_valid && $urandom_range(0, 99) < 65) begin
                    c.ev.key = last_motion_key;
                end
                else begin
                    c.ev.key.kind  = sb.kind_code;
                    c.ev.key.ptype = $urandom_range(0, 1) ? sb.move_code : sb.hover_code;
                end
                last_motion_key  = c.ev.key;
                motion_key_valid = 1'b1;
            end
            else if (pick < 65) begin
                // pointer press, release or stray type
                c.ev.key.kind = sb.kind_code;
            end
            else if (pick >= 90) begin
                c.opcode = 1'($urandom);
            end
        end
        return c;
    endfunction

    // Offer one transaction, with an occasional gap before it; returns at a falling edge
    task automatic send(input fifo_cmd_t c);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= c.opcode;
        in_ch.event_kind     <= c.ev.key.kind;
        in_ch.pointer_type   <= c.ev.key.ptype;
        in_ch.device_number  <= c.ev.key.device;
        in_ch.contact_number <= c.ev.key.contact;
        in_ch.button_mask    <= c.ev.key.buttons;
        in_ch.serial_number  <= c.ev.key.serial;
        in_ch.payload        <= c.ev.payload;
        in_ch.sink_outcome   <= c.outcome;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_transaction(c);
        @(negedge clk);
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all four registers; spare data bits of narrow registers get noise
    task automatic load_config(
        input logic [KIND_W-1:0]    kind,
        input logic [TYPE_W-1:0]    move_type,
        input logic [TYPE_W-1:0]    hover_type,
        input logic [RESERVE_W-1:0] reserve
    );
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] data [4];
        regs[0] = CFG_POINTER_KIND;
        regs[1] = CFG_MOVE_TYPE;
        regs[2] = CFG_HOVER_TYPE;
        regs[3] = CFG_RESERVE;
        data[0] = kind;
        data[1] = CFG_DATA_W'($urandom);
        data[1][TYPE_W-1:0] = move_type;
        data[2] = CFG_DATA_W'($urandom);
        data[2][TYPE_W-1:0] = hover_type;
        data[3] = CFG_DATA_W'($urandom);
        data[3][RESERVE_W-1:0] = reserve;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= data[i];
            sb.set_register(regs[i], data[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned drain_plan [PHASES];
        drain_plan = '{45, 40, 35, 55, 40, 30, 50, 45};

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.opcode         = OP_PUSH;
        in_ch.event_kind     = '0;
        in_ch.pointer_type   = '0;
        in_ch.device_number  = '0;
        in_ch.contact_number = '0;
        in_ch.button_mask    = '0;
        in_ch.serial_number  = '0;
        in_ch.payload        = '0;
        in_ch.sink_outcome   = '0;
        tx_idle_pct          = 30;
        rx_idle_pct          = 30;
        rx_hold_cycles       = 0;
        drain_pct            = 40;
        last_motion_key      = '0;
        motion_key_valid     = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part under reset configuration
        send(drain_attempt(OUTCOME_ACCEPT));                  // drain on empty queue
        send(drain_attempt(OUTCOME_BUSY));
        send(push_event(8'hFF, 4'hF, 8'hFF, 4'hF, 8'hFF, 32'hFFFF_FFFF, '1));
        send(push_event(8'h00, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0, '0));
        send(push_event(8'd1, 4'd1, 8'h5A, 4'd3, 8'h01, 32'h1234_5678,
                        64'h0001_0002_0003_0004));
        send(push_event(8'd1, 4'd1, 8'h5A, 4'd3, 8'h01, 32'h1234_5678,
                        64'hA5A5_5A5A_C3C3_3C3C));            // move coalesces
        send(push_event(8'd1, 4'd2, 8'h5A, 4'd3, 8'h01, 32'h1234_5678,
                        64'h1111_2222_3333_4444));            // hover differs in type
        send(push_event(8'd1, 4'd2, 8'h5A, 4'd3, 8'h01, 32'h1234_5678,
                        64'h8000_0000_0000_0001));            // hover coalesces
        send(drain_attempt(OUTCOME_BUSY));                    // head stays queued
        send(drain_attempt(OUTCOME_ERROR));
        send(drain_attempt(OUTCOME_UNDEF));                   // undefined outcome is an error
        send(drain_attempt(OUTCOME_ACCEPT));
        send(push_event(8'd1, 4'd0, 8'h5A, 4'd3, 8'h03, 32'h1234_5679, 64'h55));
        send(push_event(8'd1, 4'd1, 8'h5A, 4'd3, 8'h03, 32'h1234_5679, 64'h66));
        for (int i = 0; i < 7; i++) begin
            send(push_event(8'h80 | 8'(i), 4'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), $urandom, {$urandom, $urandom}));
        end
        // reserve reached: fresh motion is skipped, other events still go in until the queue is full
        send(push_event(8'd1, 4'd1, 8'h21, 4'd9, 8'h00, 32'hCAFE_0001, 64'h77));
        for (int i = 0; i < 5; i++) begin
            send(push_event(8'h40 | 8'(i), 4'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), $urandom, {$urandom, $urandom}));
        end
        wait_results_done();

        // Random phases, each under its own configuration
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_config(8'd1, 4'd1, 4'd2, 4'd4);
                1: load_config(8'd0, 4'd0, 4'd15, 4'd0);
                2: load_config(8'd255, 4'd15, 4'd15, 4'd15);
                3: load_config(8'($urandom), 4'($urandom), 4'($urandom), 4'd1);
                4: load_config(8'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
                5: load_config(8'd128, 4'd8, 4'd7, 4'd12);
                6: load_config(8'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
                default: load_config(8'd1, 4'd1, 4'd2, 4'd4);
            endcase
            drain_pct = drain_plan[phase];
            case (phase % 3)
                0: begin tx_idle_pct = 25; rx_idle_pct = 25; end
                1: begin tx_idle_pct = 10; rx_idle_pct = 40; end
                default: begin tx_idle_pct = 40; rx_idle_pct = 10; end
            endcase
            // last phase runs back to back on both sides
            if (phase == PHASES - 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // Hold off results while pushes keep coming, so the queue and the input stall
            if (phase == 1) begin
                rx_hold_cycles = 80;
                drain_pct      = 0;
                repeat (40) send(random_command());
                drain_pct      = drain_plan[phase];
            end

            repeat (PHASE_ITEMS) send(random_command());
            wait_results_done();
        end

        repeat (10) @(negedge clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end
        else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
